>>> rtl/core/kpat_pkg.sv
// Shared types and codes for the keyed profile accumulator table.
`default_nettype none
package kpat_pkg;

  // operation codes carried in tuser of the input channel
  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_COUNT  = 2'd2;
  localparam logic [1:0] MODE_GET    = 2'd3;

  localparam int KEY_W  = 32;
  localparam int TIME_W = 48;
  localparam int SUM_W  = 64;
  localparam int IDX_W  = 8;
  localparam int OCC_W  = 7;

  // request held for the whole walk and broadcast to every cell
  typedef struct packed {
    logic [1:0]        mode;
    logic [KEY_W-1:0]  dim_m;
    logic [KEY_W-1:0]  dim_n;
    logic [KEY_W-1:0]  dim_k;
    logic [TIME_W-1:0] pack_time;
    logic [TIME_W-1:0] kernel_time;
    logic [IDX_W-1:0]  slot_index;
  } kpat_req_t;

  // control token handed from cell to cell
  typedef struct packed {
    logic vld;       // token sits at this point of the chain
    logic ok;        // record placed, or get found an occupied slot
    logic counting;  // count walk has not yet met an empty slot
  } kpat_tok_t;

  // slot contents picked up by a get
  typedef struct packed {
    logic [KEY_W-1:0] dim_m;
    logic [KEY_W-1:0] dim_n;
    logic [KEY_W-1:0] dim_k;
    logic [SUM_W-1:0] calls;
    logic [SUM_W-1:0] pack_sum;
    logic [SUM_W-1:0] kernel_sum;
  } kpat_dat_t;

endpackage
`default_nettype wire

>>> rtl/core/keyed_profile_accumulator_table.sv
// Top level: request capture, chain of slot cells and output buffering.
//
//   channel | dir | ports                              | payload
//   --------+-----+------------------------------------+------------------------------
//   in      | in  | in_tvalid in_tready in_tdata in_tuser  | operation, key, times, index
//   out     | out | out_tvalid out_tready out_tdata out_tuser | ok, slot contents, count
//
// An item walks the chain one cell per cycle; its result then goes to the output
// register, or to the skid register while the output stalls. A new item is taken
// only once the previous one has left the chain and the skid register is empty.
// One item is in the chain at a time. Reset zeroes every slot count and sum at
// once. A stalled output holds one result in each of the output and skid registers.
`default_nettype none
module keyed_profile_accumulator_table
  import kpat_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // dim_m[31:0] dim_n[63:32] dim_k[95:64] pack_time[143:96]
  // kernel_time[191:144] slot_index[199:192]
  input  wire logic [199:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_m[31:0] out_n[63:32] out_k[95:64] call_count[159:96]
  // pack_time_total[223:160] kernel_time_total[287:224]
  // occupied_slots[294:288] zero[295]
  output logic [295:0]      out_tdata,
  // ok[0]
  output logic              out_tuser
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef struct packed {
    logic        ok;
    logic [295:0] data;
  } res_t;

  kpat_req_t req_r;
  logic      start_r;
  logic      busy_r;
  logic      in_fire;
  logic      out_fire;

  kpat_tok_t        tok [SLOTS+1];
  kpat_dat_t        dat [SLOTS+1];
  logic [CNT_W-1:0] cnt [SLOTS+1];

  res_t res;
  res_t out_r;
  res_t skid_r;
  logic out_vld_r;
  logic skid_vld_r;

  assign in_tready = !busy_r && !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_vld_r && out_tready;

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.mode        <= in_tuser;
      req_r.dim_m       <= in_tdata[31:0];
      req_r.dim_n       <= in_tdata[63:32];
      req_r.dim_k       <= in_tdata[95:64];
      req_r.pack_time   <= in_tdata[143:96];
      req_r.kernel_time <= in_tdata[191:144];
      req_r.slot_index  <= in_tdata[199:192];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      start_r <= in_fire;
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (tok[SLOTS].vld) begin
        busy_r <= 1'b0;
      end
    end
  end

  // token entering the first cell
  assign tok[0].vld      = start_r;
  assign tok[0].ok       = 1'b0;
  assign tok[0].counting = (req_r.mode == MODE_COUNT);
  assign dat[0]          = '0;
  assign cnt[0]          = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    kpat_cell #(
      .CELL_ID (i),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .req_i (req_r),
      .tok_i (tok[i]),
      .dat_i (dat[i]),
      .cnt_i (cnt[i]),
      .tok_o (tok[i+1]),
      .dat_o (dat[i+1]),
      .cnt_o (cnt[i+1])
    );
  end

  // result packing from the chain end
  always_comb begin
    res.ok           = tok[SLOTS].ok;
    res.data         = '0;
    res.data[31:0]   = dat[SLOTS].dim_m;
    res.data[63:32]  = dat[SLOTS].dim_n;
    res.data[95:64]  = dat[SLOTS].dim_k;
    res.data[159:96] = dat[SLOTS].calls;
    res.data[223:160] = dat[SLOTS].pack_sum;
    res.data[287:224] = dat[SLOTS].kernel_sum;
    res.data[294:288] = OCC_W'(cnt[SLOTS]);
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_fire) begin
        out_vld_r  <= skid_vld_r || tok[SLOTS].vld;
        skid_vld_r <= 1'b0;
      end else if (tok[SLOTS].vld) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_fire) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (tok[SLOTS].vld) begin
        out_r <= res;
      end
    end else if (tok[SLOTS].vld) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.ok;

endmodule
`default_nettype wire

>>> rtl/core/kpat_cell.sv
// One table slot: holds its key and sums and acts on the token passing through.
`default_nettype none
module kpat_cell
  import kpat_pkg::*;
#(
  parameter int CELL_ID = 0,
  parameter int CNT_W   = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire kpat_req_t        req_i,
  input  wire kpat_tok_t        tok_i,
  input  wire kpat_dat_t        dat_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output kpat_tok_t             tok_o,
  output kpat_dat_t             dat_o,
  output logic [CNT_W-1:0]      cnt_o
);

  logic [KEY_W-1:0] key_m_r, key_m_nxt;
  logic [KEY_W-1:0] key_n_r, key_n_nxt;
  logic [KEY_W-1:0] key_k_r, key_k_nxt;
  logic [SUM_W-1:0] calls_r, calls_nxt;
  logic [SUM_W-1:0] pack_r, pack_nxt;
  logic [SUM_W-1:0] kern_r, kern_nxt;

  kpat_tok_t        tok_r, tok_nxt;
  kpat_dat_t        dat_r, dat_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic hit;
  logic empty;
  logic idx_match;

  assign hit   = (key_m_r == req_i.dim_m) && (key_n_r == req_i.dim_n) &&
                 (key_k_r == req_i.dim_k);
  assign empty = (calls_r == '0);
  assign idx_match = ({24'd0, req_i.slot_index} == 32'(CELL_ID));

  // slot update and token handling
  always_comb begin
    key_m_nxt = key_m_r;
    key_n_nxt = key_n_r;
    key_k_nxt = key_k_r;
    calls_nxt = calls_r;
    pack_nxt  = pack_r;
    kern_nxt  = kern_r;
    tok_nxt   = tok_i;
    dat_nxt   = dat_i;
    cnt_nxt   = cnt_i;
    if (tok_i.vld) begin
      case (req_i.mode)
        MODE_RECORD: begin
          if (!tok_i.ok && (hit || empty)) begin
            key_m_nxt  = req_i.dim_m;
            key_n_nxt  = req_i.dim_n;
            key_k_nxt  = req_i.dim_k;
            calls_nxt  = calls_r + 64'd1;
            pack_nxt   = pack_r + {{(SUM_W-TIME_W){1'b0}}, req_i.pack_time};
            kern_nxt   = kern_r + {{(SUM_W-TIME_W){1'b0}}, req_i.kernel_time};
            tok_nxt.ok = 1'b1;
          end
        end
        MODE_CLEAR: begin
          key_m_nxt = '0;
          key_n_nxt = '0;
          key_k_nxt = '0;
          calls_nxt = '0;
          pack_nxt  = '0;
          kern_nxt  = '0;
        end
        MODE_COUNT: begin
          if (tok_i.counting && !empty) begin
            cnt_nxt = CNT_W'(cnt_i + 1'b1);
          end else begin
            tok_nxt.counting = 1'b0;
          end
        end
        MODE_GET: begin
          if (idx_match && !empty) begin
            tok_nxt.ok         = 1'b1;
            dat_nxt.dim_m      = key_m_r;
            dat_nxt.dim_n      = key_n_r;
            dat_nxt.dim_k      = key_k_r;
            dat_nxt.calls      = calls_r;
            dat_nxt.pack_sum   = pack_r;
            dat_nxt.kernel_sum = kern_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // counts and sums reset to zero; keys are unseen while the count is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calls_r <= '0;
      pack_r  <= '0;
      kern_r  <= '0;
      tok_r   <= '0;
    end else begin
      calls_r <= calls_nxt;
      pack_r  <= pack_nxt;
      kern_r  <= kern_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_m_r <= key_m_nxt;
    key_n_r <= key_n_nxt;
    key_k_r <= key_k_nxt;
    dat_r   <= dat_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign tok_o = tok_r;
  assign dat_o = dat_r;
  assign cnt_o = cnt_r;

endmodule
`default_nettype wire

>>> tb/sv/keyed_profile_accumulator_table_tb.sv
// Self-checking testbench for the keyed profile accumulator table.
`timescale 1ns / 100ps
module keyed_profile_accumulator_table_tb;
  import kpat_pkg::*;

  localparam int SLOTS       = 64;
  localparam int POOL_KEYS   = 80;
  localparam int CYCLE_LIMIT = 400000;

  // expected result of one item, one field per result field
  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] n;
    logic [KEY_W-1:0] k;
    logic [SUM_W-1:0] calls;
    logic [SUM_W-1:0] pack_sum;
    logic [SUM_W-1:0] kern_sum;
    logic [OCC_W-1:0] occupied;
  } slot_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [199:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [295:0] out_tdata;
  logic         out_tuser;

  keyed_profile_accumulator_table #(.SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // shadow copy of the slot store
  logic [KEY_W-1:0] tbl_m     [SLOTS];
  logic [KEY_W-1:0] tbl_n     [SLOTS];
  logic [KEY_W-1:0] tbl_k     [SLOTS];
  logic [SUM_W-1:0] tbl_calls [SLOTS];
  logic [SUM_W-1:0] tbl_pack  [SLOTS];
  logic [SUM_W-1:0] tbl_kern  [SLOTS];

  // keys reused by random records so slots get hit more than once
  logic [KEY_W-1:0] pool_m [POOL_KEYS];
  logic [KEY_W-1:0] pool_n [POOL_KEYS];
  logic [KEY_W-1:0] pool_k [POOL_KEYS];

  slot_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int errors        = 0;
  int cycles        = 0;
  int results_seen  = 0;
  int n_rec_ok      = 0;
  int n_rec_dropped = 0;
  int n_get_hit     = 0;
  int n_get_miss    = 0;
  int n_count       = 0;
  int n_clear       = 0;

  // apply one item to the shadow store and return its result
  function automatic slot_result_t table_apply(kpat_req_t r);
    slot_result_t res;
    int i;
    int cnt;
    logic placed;
    res = '0;
    placed = 1'b0;
    case (r.mode)
      MODE_RECORD: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!placed && ((tbl_m[i] == r.dim_m && tbl_n[i] == r.dim_n && tbl_k[i] == r.dim_k)
                          || tbl_calls[i] == '0)) begin
            tbl_m[i]     = r.dim_m;
            tbl_n[i]     = r.dim_n;
            tbl_k[i]     = r.dim_k;
            tbl_calls[i] = tbl_calls[i] + 64'd1;
            tbl_pack[i]  = tbl_pack[i] + {16'd0, r.pack_time};
            tbl_kern[i]  = tbl_kern[i] + {16'd0, r.kernel_time};
            placed       = 1'b1;
          end
        end
        res.ok = placed;
        if (placed) n_rec_ok++;
        else n_rec_dropped++;
      end
      MODE_CLEAR: begin
        for (i = 0; i < SLOTS; i++) begin
          tbl_m[i]     = '0;
          tbl_n[i]     = '0;
          tbl_k[i]     = '0;
          tbl_calls[i] = '0;
          tbl_pack[i]  = '0;
          tbl_kern[i]  = '0;
        end
        n_clear++;
      end
      MODE_COUNT: begin
        cnt = 0;
        while (cnt < SLOTS && tbl_calls[cnt] != '0) cnt++;
        res.occupied = cnt[OCC_W-1:0];
        n_count++;
      end
      default: begin
        if (r.slot_index < SLOTS && tbl_calls[r.slot_index] != '0) begin
          res.ok       = 1'b1;
          res.m        = tbl_m[r.slot_index];
          res.n        = tbl_n[r.slot_index];
          res.k        = tbl_k[r.slot_index];
          res.calls    = tbl_calls[r.slot_index];
          res.pack_sum = tbl_pack[r.slot_index];
          res.kern_sum = tbl_kern[r.slot_index];
          n_get_hit++;
        end else begin
          n_get_miss++;
        end
      end
    endcase
    return res;
  endfunction

  function automatic kpat_req_t make_req(logic [1:0] mode, logic [KEY_W-1:0] m,
                                         logic [KEY_W-1:0] n, logic [KEY_W-1:0] k,
                                         logic [TIME_W-1:0] pt, logic [TIME_W-1:0] kt,
                                         logic [IDX_W-1:0] idx);
    kpat_req_t r;
    r.mode        = mode;
    r.dim_m       = m;
    r.dim_n       = n;
    r.dim_k       = k;
    r.pack_time   = pt;
    r.kernel_time = kt;
    r.slot_index  = idx;
    return r;
  endfunction

  // time value: zero, all ones or random over the full 48 bits
  function automatic logic [TIME_W-1:0] rand_time();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {16'($urandom_range(0, 65535)), 32'($urandom)};
  endfunction

  // random item: mostly records over the key pool, unused fields left random
  function automatic kpat_req_t random_item();
    kpat_req_t r;
    int sel;
    int pick;
    r = make_req(MODE_RECORD, $urandom, $urandom, $urandom, rand_time(), rand_time(),
                 8'($urandom_range(0, 255)));
    sel = $urandom_range(0, 999);
    if (sel < 15) begin
      r.mode = MODE_CLEAR;
    end else if (sel < 115) begin
      r.mode = MODE_COUNT;
    end else if (sel < 400) begin
      r.mode = MODE_GET;
      if ($urandom_range(0, 4) != 0) r.slot_index = 8'($urandom_range(0, 15));
      else if ($urandom_range(0, 1) != 0) r.slot_index = 8'($urandom_range(0, SLOTS - 1));
    end else if ($urandom_range(0, 19) != 0) begin
      pick = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15)
                                         : $urandom_range(0, POOL_KEYS - 1);
      r.dim_m = pool_m[pick];
      r.dim_n = pool_n[pick];
      r.dim_k = pool_k[pick];
    end
    return r;
  endfunction

  // offer one item, wait for acceptance, then log its expected result
  task automatic send_item(input kpat_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.slot_index, r.kernel_time, r.pack_time, r.dim_k, r.dim_n, r.dim_m};
    in_tuser  <= r.mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(table_apply(r));
  endtask

  // stop offering and wait until every expected result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // extremes of every field, each mode, get out of range and on an empty slot
  task automatic test_directed();
    send_item(make_req(MODE_COUNT, '1, '1, '1, '1, '1, '1));
    send_item(make_req(MODE_GET, '1, '1, '1, '1, '1, 8'd0));
    send_item(make_req(MODE_RECORD, '0, '0, '0, '0, '0, '1));
    send_item(make_req(MODE_RECORD, '1, '1, '1, '1, '1, '0));
    send_item(make_req(MODE_RECORD, '1, '1, '1, '1, '1, '0));
    // same m and n, different k: must take a new slot
    send_item(make_req(MODE_RECORD, '1, '1, '0, 48'd1, 48'd2, '0));
    send_item(make_req(MODE_RECORD, '0, '0, '0, 48'h123456789abc, 48'h0, '0));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'd0));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'd1));
    send_item(make_req(MODE_GET, '1, '1, '1, '1, '1, 8'd2));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'd3));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'(SLOTS - 1)));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'(SLOTS)));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'd255));
    send_item(make_req(MODE_COUNT, '0, '0, '0, '0, '0, '0));
    send_item(make_req(MODE_CLEAR, '1, '1, '1, '1, '1, '1));
    send_item(make_req(MODE_COUNT, '0, '0, '0, '0, '0, '0));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'd1));
    wait_drained();
  endtask

  // fill every slot, then a new key is dropped while a known key still lands
  task automatic test_table_full();
    logic [KEY_W-1:0] fill_n [SLOTS];
    int i;
    send_item(make_req(MODE_CLEAR, $urandom, $urandom, $urandom, '0, '0, '0));
    for (i = 0; i < SLOTS; i++) begin
      fill_n[i] = $urandom;
      send_item(make_req(MODE_RECORD, 32'h1000_0000 + 32'(i), fill_n[i], 32'(i),
                         rand_time(), rand_time(), 8'($urandom_range(0, 255))));
    end
    send_item(make_req(MODE_RECORD, 32'hffff_0000, 32'd7, 32'd7, '1, '1, '0));
    send_item(make_req(MODE_RECORD, 32'h1000_000a, fill_n[10], 32'd10, '1, '1, '0));
    send_item(make_req(MODE_COUNT, '0, '0, '0, '0, '0, '0));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'd10));
    send_item(make_req(MODE_GET, '0, '0, '0, '0, '0, 8'(SLOTS - 1)));
    send_item(make_req(MODE_CLEAR, '0, '0, '0, '0, '0, '0));
    send_item(make_req(MODE_COUNT, '0, '0, '0, '0, '0, '0));
    wait_drained();
  endtask

  // receiver holds off long enough that results back up and input stalls
  task automatic test_output_hold();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1200;
    for (i = 0; i < 12; i++) send_item(random_item());
    wait_drained();
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < count; i++) send_item(random_item());
    wait_drained();
  endtask

  // receiver side: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // compare each result against the oldest expectation
  always @(posedge clk) begin : result_check
    slot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("ok", 64'(want.ok), 64'(out_tuser));
        check_field("out_m", 64'(want.m), 64'(out_tdata[31:0]));
        check_field("out_n", 64'(want.n), 64'(out_tdata[63:32]));
        check_field("out_k", 64'(want.k), 64'(out_tdata[95:64]));
        check_field("call_count", want.calls, out_tdata[159:96]);
        check_field("pack_time_total", want.pack_sum, out_tdata[223:160]);
        check_field("kernel_time_total", want.kern_sum, out_tdata[287:224]);
        check_field("occupied_slots", 64'(want.occupied), 64'(out_tdata[294:288]));
        check_field("pad", 64'd0, 64'(out_tdata[295]));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("keyed_profile_accumulator_table: mismatch");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) begin
      tbl_m[i]     = '0;
      tbl_n[i]     = '0;
      tbl_k[i]     = '0;
      tbl_calls[i] = '0;
      tbl_pack[i]  = '0;
      tbl_kern[i]  = '0;
    end
    // pool: all-zero key, all-ones key, then random keys each followed by a near miss
    pool_m[0] = '0;
    pool_n[0] = '0;
    pool_k[0] = '0;
    pool_m[1] = '1;
    pool_n[1] = '1;
    pool_k[1] = '1;
    for (i = 2; i < POOL_KEYS; i += 2) begin
      pool_m[i]     = $urandom;
      pool_n[i]     = $urandom;
      pool_k[i]     = $urandom;
      pool_m[i + 1] = pool_m[i];
      pool_n[i + 1] = pool_n[i];
      pool_k[i + 1] = pool_k[i];
      case ($urandom_range(0, 2))
        0: pool_m[i + 1] = pool_m[i] ^ (32'd1 << $urandom_range(0, 31));
        1: pool_n[i + 1] = pool_n[i] ^ (32'd1 << $urandom_range(0, 31));
        default: pool_k[i + 1] = pool_k[i] ^ (32'd1 << $urandom_range(0, 31));
      endcase
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_output_hold();
    test_random(140, 31, 51);
    test_random(140, 51, 31);
    test_random(120, 0, 0);

    repeat (SLOTS + 10) @(posedge clk);
    $display("results checked %0d: records stored %0d, dropped on full table %0d",
             results_seen, n_rec_ok, n_rec_dropped);
    $display("gets hit %0d, gets missed %0d, counts %0d, clears %0d",
             n_get_hit, n_get_miss, n_count, n_clear);
    if (errors == 0) begin
      $display("keyed_profile_accumulator_table: match");
    end else begin
      $display("keyed_profile_accumulator_table: mismatch");
    end
    $finish;
  end

endmodule
